// ===== rtl/core/tach_pkg.sv =====
`timescale 1ns / 1ps

package tach_pkg;

    // Width of the rate constant, which is the dividend of the rate division.
    localparam int RC_W  = 32;
    localparam int CNT_W = $clog2(RC_W + 1);

    // Overflow counters and the fixed field widths.
    localparam int OVF_W  = 8;
    localparam int RATE_W = 16;
    localparam int CAPT_W = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RATE_CONSTANT = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_LIMIT = 2'd1;
    localparam logic [1:0] CFG_RATE_MAX      = 2'd2;

    typedef enum logic [1:0] {
        KIND_UNCHANGED = 2'd0,
        KIND_MEASURED  = 2'd1,
        KIND_TIMEOUT   = 2'd2
    } t_update_kind;

    typedef struct packed {
        logic              first_pulse_seen;
        logic              period_captured;
        logic [CAPT_W-1:0] captured_count;
    } t_in_beat;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        t_update_kind      update_kind;
        logic              rearm_request;
    } t_out_beat;

endpackage

// ===== rtl/core/tach_div.sv =====
`timescale 1ns / 1ps

module tach_div import tach_pkg::*; #(
    parameter int DIVISOR_W = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [RC_W-1:0]      i_dividend,
    input  logic [DIVISOR_W-1:0] i_divisor,
    output logic                 o_done,
    output logic [RC_W-1:0]      o_quot
);

    // Restoring division: the dividend shifts out of r_quot one bit per cycle
    // at the top while quotient bits shift in at the bottom.
    logic [DIVISOR_W-1:0] r_rem, n_rem;
    logic [RC_W-1:0]      r_quot, n_quot;
    logic [DIVISOR_W-1:0] r_div;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;

    logic [DIVISOR_W:0]   w_trial;
    logic [DIVISOR_W:0]   w_diff;
    logic                 w_fit;

    assign w_trial = {r_rem, r_quot[RC_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_rem  = r_rem;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quot = i_dividend;
            n_cnt  = CNT_W'(RC_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = w_fit ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            n_quot = {r_quot[RC_W-2:0], w_fit};
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quot <= n_quot;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/core/period_to_rate_tachometer.sv =====
`timescale 1ns / 1ps
// An overflow beat, or a capture of zero ticks, goes straight to the result register r_res
// (state ST_DONE); any other capture first runs a restoring divider, one quotient bit per
// cycle over the 32-bit rate constant, and its saturated quotient then goes to r_res.
// One beat at a time: a new beat is taken once the previous result has moved from r_res
// into the output register, and that move waits while the output is stalled.
// Reset (synchronous, active low) restores register defaults, clears counters, rate, valids.

module period_to_rate_tachometer import tach_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_beat        i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_beat       o_out_data,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [RC_W-1:0] i_cfg_data
);

    localparam int TICK_W = COUNT_WIDTH + OVF_W;
    localparam logic [TICK_W-1:0] CNT_MASK = {{OVF_W{1'b0}}, {COUNT_WIDTH{1'b1}}};

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [RC_W-1:0]   r_rate_constant;
    logic [OVF_W-1:0]  r_timeout_limit;
    logic [RATE_W-1:0] r_rate_max;
    logic [OVF_W-1:0]  r_po, n_po;
    logic [OVF_W-1:0]  r_io, n_io;
    logic [RATE_W-1:0] r_held_rate, n_held_rate;
    t_out_beat         r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out_data, n_out_data;

    logic              w_accept;
    logic              w_slot_free;
    logic [TICK_W-1:0] w_ticks;
    logic              w_div_start;
    logic              w_div_done;
    logic [RC_W-1:0]   w_quot;
    logic [RATE_W-1:0] w_sat_rate;
    logic [OVF_W-1:0]  w_po_inc;
    logic [OVF_W-1:0]  w_io_inc;
    logic              w_timeout;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Pulse overflows sit above the low count bits, so OR stands for the add.
    assign w_ticks = (TICK_W'(i_in_data.captured_count) & CNT_MASK)
                   | {r_po, {COUNT_WIDTH{1'b0}}};

    assign w_div_start = w_accept && i_in_data.period_captured && (w_ticks != '0);

    tach_div #(
        .DIVISOR_W (TICK_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rate_constant),
        .i_divisor  (w_ticks),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_sat_rate = ((|w_quot[RC_W-1:RATE_W]) || (w_quot[RATE_W-1:0] > r_rate_max))
                      ? r_rate_max : w_quot[RATE_W-1:0];

    assign w_po_inc  = i_in_data.first_pulse_seen ? r_po + OVF_W'(1) : r_po;
    assign w_io_inc  = i_in_data.first_pulse_seen ? r_io : r_io + OVF_W'(1);
    assign w_timeout = (w_po_inc >= r_timeout_limit) || (w_io_inc >= r_timeout_limit);

    always_comb begin
        n_state     = r_state;
        n_po        = r_po;
        n_io        = r_io;
        n_held_rate = r_held_rate;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.period_captured) begin
                        n_po = '0;
                        n_io = '0;
                        if (w_ticks == '0) begin
                            // zero ticks saturate
                            n_held_rate = r_rate_max;
                            n_res       = '{r_rate_max, KIND_MEASURED, 1'b0};
                            n_state     = ST_DONE;
                        end else begin
                            n_state = ST_DIV;
                        end
                    end else if (w_timeout) begin
                        n_po        = '0;
                        n_io        = '0;
                        n_held_rate = '0;
                        n_res       = '{'0, KIND_TIMEOUT, 1'b1};
                        n_state     = ST_DONE;
                    end else begin
                        n_po    = w_po_inc;
                        n_io    = w_io_inc;
                        n_res   = '{r_held_rate, KIND_UNCHANGED, 1'b0};
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_held_rate = w_sat_rate;
                    n_res       = '{w_sat_rate, KIND_MEASURED, 1'b0};
                    n_state     = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_rate_constant <= RC_W'(1000000);
            r_timeout_limit <= OVF_W'(3);
            r_rate_max      <= RATE_W'(255);
            r_po            <= '0;
            r_io            <= '0;
            r_held_rate     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_po        <= n_po;
            r_io        <= n_io;
            r_held_rate <= n_held_rate;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RATE_CONSTANT: r_rate_constant <= i_cfg_data;
                    CFG_TIMEOUT_LIMIT: r_timeout_limit <= i_cfg_data[OVF_W-1:0];
                    CFG_RATE_MAX:      r_rate_max      <= i_cfg_data[RATE_W-1:0];
                    default: begin
                        // drop writes to unknown indexes
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_timeout_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.update_kind == KIND_TIMEOUT))
            |-> (o_out_data.rate == '0) && o_out_data.rearm_request)
        else $error("timeout beat without zero rate and rearm");

    a_rearm_only_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.rearm_request)
            |-> (o_out_data.update_kind == KIND_TIMEOUT))
        else $error("rearm request outside a timeout");

    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> (r_state == ST_DIV) && (r_po == '0) && (r_io == '0))
        else $error("capture did not start the division with cleared counters");

    a_counters_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_po == '0) && (r_io == '0) && !o_in_ready)
        else $error("counters moved or input open during division");

endmodule

// ===== tb/period_to_rate_tachometer_tb.sv =====
`timescale 1ns / 1ps

module period_to_rate_tachometer_tb;
    import tach_pkg::*;

    localparam int TICK_SHIFT      = 16;
    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 250;

    // Index with no register behind it; writes must be dropped.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_BURSTY
    } t_rx_mode;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  idx;
        logic [31:0] val;
        t_in_beat    beat;
        logic        typed;
        t_out_beat   expd;
    } t_dir_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_ready;
    t_in_beat        i_in_data = '0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    t_out_beat       o_out_data;
    logic            i_cfg_we = 1'b0;
    logic [1:0]      i_cfg_idx = '0;
    logic [RC_W-1:0] i_cfg_data = '0;

    // Shadow of the block's registers and state
    logic [31:0]       rate_const;
    logic [7:0]        tmo_limit;
    logic [RATE_W-1:0] rate_max;
    logic [OVF_W-1:0]  pulse_ovf;
    logic [OVF_W-1:0]  idle_ovf;
    logic [RATE_W-1:0] held_rate;

    t_out_beat pending_rates[$];
    t_out_beat want;
    int        mismatches = 0;
    int        sent = 0;
    int        n_meas = 0;
    int        n_tmo = 0;
    int        n_cfg = 0;
    int        burst_left = 0;
    int        cycles = 0;
    t_rx_mode  rx_mode = RX_OPEN;
    int        rx_mode_left = 0;
    int        rx_stall_left = 0;

    // Directed beats start from the register defaults right after reset.
    t_dir_row dir_tab [0:32] = '{
        '{1'b0, 2'd0, 32'd0, '{1'b0, 1'b0, 16'h0000}, 1'b1, '{16'd0, KIND_UNCHANGED, 1'b0}},
        '{1'b0, 2'd0, 32'd0, '{1'b0, 1'b0, 16'hFFFF}, 1'b1, '{16'd0, KIND_UNCHANGED, 1'b0}},
        '{1'b0, 2'd0, 32'd0, '{1'b0, 1'b0, 16'h0000}, 1'b1, '{16'd0, KIND_TIMEOUT, 1'b1}},
        '{1'b0, 2'd0, 32'd0, '{1'b0, 1'b1, 16'h0000}, 1'b1, '{16'd255, KIND_MEASURED, 1'b0}},
        '{1'b0, 2'd0, 32'd0, '{1'b1, 1'b1, 16'hFFFF}, 1'b1, '{16'd15, KIND_MEASURED, 1'b0}},
        '{1'b0, 2'd0, 32'd0, '{1'b1, 1'b0, 16'h0000}, 1'b1, '{16'd15, KIND_UNCHANGED, 1'b0}},
        '{1'b0, 2'd0, 32'd0, '{1'b1, 1'b0, 16'hFFFF}, 1'b1, '{16'd15, KIND_UNCHANGED, 1'b0}},
        '{1'b0, 2'd0, 32'd0, '{1'b1, 1'b1, 16'h0000}, 1'b1, '{16'd7, KIND_MEASURED, 1'b0}},
        '{1'b0, 2'd0, 32'd0, '{1'b1, 1'b1, 16'h0001}, 1'b1, '{16'd255, KIND_MEASURED, 1'b0}},
        '{1'b0, 2'd0, 32'd0, '{1'b0, 1'b1, 16'd3922}, 1'b0, '0},
        '{1'b0, 2'd0, 32'd0, '{1'b0, 1'b1, 16'd3921}, 1'b0, '0},
        '{1'b0, 2'd0, 32'd0, '{1'b1, 1'b0, 16'h0000}, 1'b0, '0},
        '{1'b0, 2'd0, 32'd0, '{1'b0, 1'b0, 16'h0000}, 1'b0, '0},
        '{1'b0, 2'd0, 32'd0, '{1'b1, 1'b0, 16'h0000}, 1'b0, '0},
        '{1'b0, 2'd0, 32'd0, '{1'b0, 1'b0, 16'h0000}, 1'b0, '0},
        '{1'b0, 2'd0, 32'd0, '{1'b1, 1'b0, 16'h0000}, 1'b1, '{16'd0, KIND_TIMEOUT, 1'b1}},
        '{1'b0, 2'd0, 32'd0, '{1'b1, 1'b1, 16'hAAAA}, 1'b0, '0},
        '{1'b0, 2'd0, 32'd0, '{1'b0, 1'b1, 16'h5555}, 1'b0, '0},
        '{1'b1, CFG_RATE_CONSTANT, 32'hFFFF_FFFF, '0, 1'b0, '0},
        '{1'b1, CFG_TIMEOUT_LIMIT, 32'd255, '0, 1'b0, '0},
        '{1'b1, CFG_RATE_MAX, 32'd65535, '0, 1'b0, '0},
        '{1'b0, 2'd0, 32'd0, '{1'b0, 1'b1, 16'h0001}, 1'b1, '{16'hFFFF, KIND_MEASURED, 1'b0}},
        '{1'b0, 2'd0, 32'd0, '{1'b1, 1'b0, 16'h1234}, 1'b0, '0},
        '{1'b0, 2'd0, 32'd0, '{1'b1, 1'b1, 16'hFFFF}, 1'b0, '0},
        '{1'b1, CFG_UNUSED, 32'd0, '0, 1'b0, '0},
        '{1'b1, CFG_RATE_CONSTANT, 32'd1, '0, 1'b0, '0},
        '{1'b1, CFG_TIMEOUT_LIMIT, 32'd1, '0, 1'b0, '0},
        '{1'b1, CFG_RATE_MAX, 32'd1, '0, 1'b0, '0},
        '{1'b0, 2'd0, 32'd0, '{1'b1, 1'b0, 16'h0000}, 1'b1, '{16'd0, KIND_TIMEOUT, 1'b1}},
        '{1'b0, 2'd0, 32'd0, '{1'b0, 1'b1, 16'h0001}, 1'b1, '{16'd1, KIND_MEASURED, 1'b0}},
        // zero limits: every overflow times out, every measurement is clamped to zero
        '{1'b1, CFG_RATE_MAX, 32'd0, '0, 1'b0, '0},
        '{1'b1, CFG_TIMEOUT_LIMIT, 32'd0, '0, 1'b0, '0},
        '{1'b0, 2'd0, 32'd0, '{1'b0, 1'b1, 16'h0000}, 1'b1, '{16'd0, KIND_MEASURED, 1'b0}}
    };

    period_to_rate_tachometer #(
        .COUNT_WIDTH(TICK_SHIFT)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_out_beat tach_step(input t_in_beat b);
        logic [63:0] ticks;
        logic [63:0] quot;
        t_out_beat   r;
        r.update_kind   = KIND_UNCHANGED;
        r.rearm_request = 1'b0;
        if (b.period_captured) begin
            ticks = 64'(b.captured_count) + (64'(pulse_ovf) << TICK_SHIFT);
            if (ticks == 64'd0) begin
                held_rate = rate_max;
            end else begin
                quot      = 64'(rate_const) / ticks;
                held_rate = (quot > 64'(rate_max)) ? rate_max : quot[RATE_W-1:0];
            end
            pulse_ovf     = '0;
            idle_ovf      = '0;
            r.update_kind = KIND_MEASURED;
            n_meas++;
        end else begin
            if (b.first_pulse_seen)
                pulse_ovf = pulse_ovf + 8'd1;
            else
                idle_ovf = idle_ovf + 8'd1;
            if (idle_ovf >= tmo_limit || pulse_ovf >= tmo_limit) begin
                pulse_ovf       = '0;
                idle_ovf        = '0;
                held_rate       = '0;
                r.update_kind   = KIND_TIMEOUT;
                r.rearm_request = 1'b1;
                n_tmo++;
            end
        end
        r.rate = held_rate;
        return r;
    endfunction

    // Send one timer event; bursts of random length with random gaps in between.
    task automatic send_event(input t_in_beat b, input logic typed, input t_out_beat fixed);
        int        gap;
        t_out_beat p;
        i_cfg_we <= 1'b0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(40, 120))
                                                     : int'($urandom_range(1, 16));
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        p = tach_step(b);
        pending_rates.push_back(typed ? fixed : p);
        sent++;
    endtask

    // Hold the sender until every result is out and the divider has gone quiet.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        i_cfg_we   <= 1'b0;
        while (pending_rates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    // The write enable is dropped by the next beat, so back-to-back writes stay clean.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_RATE_CONSTANT: rate_const = val;
            CFG_TIMEOUT_LIMIT: tmo_limit  = val[7:0];
            CFG_RATE_MAX:      rate_max   = val[RATE_W-1:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rates.size() == 0) begin
                $error("unexpected result beat: rate %0d kind %0d rearm %0d",
                       o_out_data.rate, o_out_data.update_kind, o_out_data.rearm_request);
                mismatches++;
            end else begin
                want = pending_rates.pop_front();
                if (o_out_data.rate !== want.rate) begin
                    $error("rate: expected %0d, got %0d", want.rate, o_out_data.rate);
                    mismatches++;
                end
                if (o_out_data.update_kind !== want.update_kind) begin
                    $error("update_kind: expected %0d, got %0d",
                           want.update_kind, o_out_data.update_kind);
                    mismatches++;
                end
                if (o_out_data.rearm_request !== want.rearm_request) begin
                    $error("rearm_request: expected %0d, got %0d",
                           want.rearm_request, o_out_data.rearm_request);
                    mismatches++;
                end
            end
        end

        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 2));
            rx_mode_left = 200;
        end
        rx_mode_left--;
        case (rx_mode)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_RANDOM: i_out_ready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (rx_stall_left != 0) begin
                    rx_stall_left--;
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        rx_stall_left = $urandom_range(1, 15);
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_in_beat    b;
        logic [31:0] rc;
        logic [31:0] tl;
        logic [31:0] rm;
        int          n;
        int          target;

        rate_const = 32'd1000000;
        tmo_limit  = 8'd3;
        rate_max   = 16'd255;
        pulse_ovf  = '0;
        idle_ovf   = '0;
        held_rate  = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                if (i == 0 || !dir_tab[i - 1].is_cfg)
                    wait_idle();
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            end else begin
                send_event(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].expd);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin rc = 32'd1;          tl = 32'd1;   rm = 32'd1;     end
                1: begin rc = 32'hFFFF_FFFF;  tl = 32'd255; rm = 32'd65535; end
                2: begin rc = 32'd1000000;    tl = 32'd3;   rm = 32'd255;   end
                default: begin
                    rc = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(1, 32'h00FF_FFFF))
                                                     : $urandom();
                    if (rc == 32'd0)
                        rc = 32'd1;
                    tl = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(1, 255))
                                                     : 32'($urandom_range(1, 8));
                    rm = 32'($urandom_range(1, 65535));
                end
            endcase
            write_reg(CFG_RATE_CONSTANT, rc);
            write_reg(CFG_TIMEOUT_LIMIT, tl);
            write_reg(CFG_RATE_MAX, rm);

            target = sent + ITEMS_PER_PHASE;
            while (sent < target) begin
                if ($urandom_range(0, 199) == 0)
                    wait_idle();
                if ($urandom_range(0, 4) == 0) begin
                    // noise: any flag combination, any count
                    b.first_pulse_seen = 1'($urandom_range(0, 1));
                    b.period_captured  = 1'($urandom_range(0, 1));
                    b.captured_count   = 16'($urandom());
                    send_event(b, 1'b0, '0);
                end else begin
                    // idle overflows, then overflows inside the period, then the capture
                    n = $urandom_range(0, 2);
                    repeat (n) begin
                        b.first_pulse_seen = 1'b0;
                        b.period_captured  = 1'b0;
                        b.captured_count   = 16'($urandom());
                        send_event(b, 1'b0, '0);
                    end
                    if ($urandom_range(0, 19) == 0)
                        n = $urandom_range(0, int'(tmo_limit));
                    else
                        n = $urandom_range(0, (tmo_limit < 8'd6) ? int'(tmo_limit) : 6);
                    repeat (n) begin
                        b.first_pulse_seen = 1'b1;
                        b.period_captured  = 1'b0;
                        b.captured_count   = 16'($urandom());
                        send_event(b, 1'b0, '0);
                    end
                    b.first_pulse_seen = 1'($urandom_range(0, 1));
                    b.period_captured  = 1'b1;
                    case ($urandom_range(0, 3))
                        0:       b.captured_count = 16'($urandom_range(0, 63));
                        1:       b.captured_count = 16'($urandom_range(65472, 65535));
                        default: b.captured_count = 16'($urandom());
                    endcase
                    send_event(b, 1'b0, '0);
                end
            end
        end

        wait_idle();
        $display("Sent %0d timer events across %0d register writes", sent, n_cfg);
        $display("Saw %0d period measurements and %0d timeouts", n_meas, n_tmo);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== period_to_rate_tachometer.f =====
rtl/core/tach_pkg.sv
rtl/core/tach_div.sv
rtl/core/period_to_rate_tachometer.sv
tb/period_to_rate_tachometer_tb.sv
